/* rtl/stcf_pkg.sv */
package stcf_pkg;

   typedef enum logic [2:0] {
      OP_A_MINUS_X = 3'd0,
      OP_X_MINUS_A = 3'd1,
      OP_ABS       = 3'd2,
      OP_SHIFT     = 3'd3,
      OP_CLR_LEFT  = 3'd4,
      OP_CLR_RIGHT = 3'd5,
      OP_ADD_CONST = 3'd6,
      OP_QUERY     = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_REVERSED = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      HOP_PUSH    = 2'd0,
      HOP_REPLACE = 2'd1,
      HOP_CLEAR   = 2'd2
   } heap_op_type;

   typedef logic signed [49:0] entry_type;

   typedef struct packed {
      logic        start;
      heap_op_type op;
      entry_type   value;
   } heap_cmd_type;

endpackage

/* rtl/slope_trick_convex_function_top.sv */
// From accepted beat to rsp_valid: shift, clear, add-constant and query go S_EVAL, S_DONE;
// one-sided adds also wait in S_WAIT1 for the heaps, and add_abs adds S_PH2 and S_WAIT2; the
// wait is set by the sift-down level (check, two child reads, compare) on one memory port.
// Throughput: one beat in flight; the next beat is taken the cycle after the result loads.
// A stalled result register holds the finished beat in S_DONE and the input stays stalled.
// Reset: synchronous, active high; clears counts, offsets and the minimum.
module slope_trick_convex_function_top
   import stcf_pkg::*;
#(
   parameter int HEAP_CAPACITY = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_value_a,
   input  logic signed [31:0] req_value_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [63:0] rsp_minimum_value,
   output logic signed [50:0] rsp_left_end,
   output logic               rsp_left_bounded,
   output logic signed [50:0] rsp_right_end,
   output logic               rsp_right_bounded
);

   localparam int CW = $clog2(HEAP_CAPACITY + 1);

   typedef enum logic [2:0] {S_IDLE, S_EVAL, S_WAIT1, S_PH2, S_WAIT2, S_DONE} state_type;

   state_type          state_ff, state_in;
   opcode_type         op_ff;
   logic signed [31:0] a_ff, b_ff;
   logic [1:0]         status_ff, status_in;
   logic signed [47:0] loff_ff, loff_in, roff_ff, roff_in;
   logic signed [63:0] macc_ff, macc_in;
   logic               rvalid_ff;
   logic [1:0]         rstatus_ff;
   logic signed [63:0] rmin_ff;
   logic signed [50:0] rleft_ff, rright_ff;
   logic               rlb_ff, rrb_ff;

   heap_cmd_type  lcmd, rcmd;
   logic          lbusy, rbusy;
   logic [CW-1:0] lcnt, rcnt;
   entry_type     ltop, rtop;

   logic signed [51:0] a52, tl, tr, delta, pushed, new_top;
   logic signed [48:0] nl, nr;
   logic               lne, rne, mv0, mv1, lfull, rfull, xm_phase;
   logic signed [64:0] msum;

   stcf_heap #(.HEAP_CAPACITY(HEAP_CAPACITY), .IS_MIN(1'b0)) u_left (
      .clock(clock), .reset(reset), .cmd(lcmd), .busy(lbusy), .count(lcnt), .top(ltop));
   stcf_heap #(.HEAP_CAPACITY(HEAP_CAPACITY), .IS_MIN(1'b1)) u_right (
      .clock(clock), .reset(reset), .cmd(rcmd), .busy(rbusy), .count(rcnt), .top(rtop));

   function automatic logic fits50(input logic signed [51:0] v);
      return (v[51:49] == 3'b000) || (v[51:49] == 3'b111);
   endfunction

   assign a52   = 52'(a_ff);
   assign tl    = 52'(ltop) + 52'(loff_ff);
   assign tr    = 52'(rtop) + 52'(roff_ff);
   assign lne   = (lcnt != '0);
   assign rne   = (rcnt != '0);
   assign lfull = (lcnt == CW'(HEAP_CAPACITY));
   assign rfull = (rcnt == CW'(HEAP_CAPACITY));
   assign mv0   = rne && (tr < a52);
   assign mv1   = lne && (a52 < tl);
   assign pushed  = mv0 ? tr : a52;
   assign new_top = (lne && (tl > pushed)) ? tl : pushed;
   assign nl    = 49'(loff_ff) + 49'(a_ff);
   assign nr    = 49'(roff_ff) + 49'(b_ff);
   assign xm_phase = (state_ff == S_PH2) || (op_ff == OP_X_MINUS_A);
   assign delta = xm_phase ? (tl - a52) : (a52 - tr);
   assign msum  = 65'(macc_ff) + ((op_ff == OP_ADD_CONST) ? 65'(a_ff) : 65'(delta));

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      loff_in   = loff_ff;
      roff_in   = roff_ff;
      macc_in   = macc_ff;
      lcmd      = '{start: 1'b0, op: HOP_PUSH, value: '0};
      rcmd      = '{start: 1'b0, op: HOP_PUSH, value: '0};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL, S_PH2: begin
            status_in = ST_OK;
            state_in  = S_DONE;
            if (state_ff == S_EVAL) begin
               case (op_ff)
                  OP_A_MINUS_X: begin
                     if (lfull) status_in = ST_FULL;
                     else if (mv0 && !fits50(tr - 52'(loff_ff))) status_in = ST_RANGE;
                  end
                  OP_X_MINUS_A: begin
                     if (rfull) status_in = ST_FULL;
                     else if (mv1 && !fits50(tl - 52'(roff_ff))) status_in = ST_RANGE;
                  end
                  OP_ABS: begin
                     if (lfull || rfull) status_in = ST_FULL;
                     else if (mv0 && !fits50(pushed - 52'(loff_ff))) status_in = ST_RANGE;
                     else if ((a52 < new_top) && !fits50(new_top - 52'(roff_ff)))
                        status_in = ST_RANGE;
                  end
                  OP_SHIFT: begin
                     if (a_ff > b_ff) status_in = ST_REVERSED;
                     else if ((nl[48] != nl[47]) || (nr[48] != nr[47])) status_in = ST_RANGE;
                     else begin
                        loff_in = nl[47:0];
                        roff_in = nr[47:0];
                     end
                  end
                  OP_CLR_LEFT: lcmd = '{start: 1'b1, op: HOP_CLEAR, value: '0};
                  OP_CLR_RIGHT: rcmd = '{start: 1'b1, op: HOP_CLEAR, value: '0};
                  OP_ADD_CONST: begin
                     macc_in = (msum[64] != msum[63]) ?
                               {msum[64], {63{~msum[64]}}} : msum[63:0];
                  end
                  default: ;
               endcase
            end
            if ((status_in == ST_OK) && (op_ff == OP_A_MINUS_X || op_ff == OP_X_MINUS_A ||
                op_ff == OP_ABS)) begin
               state_in = (state_ff == S_PH2) ? S_WAIT2 : S_WAIT1;
               if (!xm_phase) begin
                  if (mv0) begin
                     macc_in = (msum[64] != msum[63]) ?
                               {msum[64], {63{~msum[64]}}} : msum[63:0];
                     rcmd = '{start: 1'b1, op: HOP_REPLACE, value: 50'(a52 - 52'(roff_ff))};
                     lcmd = '{start: 1'b1, op: HOP_PUSH, value: 50'(tr - 52'(loff_ff))};
                  end else begin
                     lcmd = '{start: 1'b1, op: HOP_PUSH, value: 50'(a52 - 52'(loff_ff))};
                  end
               end else begin
                  if (mv1) begin
                     macc_in = (msum[64] != msum[63]) ?
                               {msum[64], {63{~msum[64]}}} : msum[63:0];
                     lcmd = '{start: 1'b1, op: HOP_REPLACE, value: 50'(a52 - 52'(loff_ff))};
                     rcmd = '{start: 1'b1, op: HOP_PUSH, value: 50'(tl - 52'(roff_ff))};
                  end else begin
                     rcmd = '{start: 1'b1, op: HOP_PUSH, value: 50'(a52 - 52'(roff_ff))};
                  end
               end
            end
         end
         S_WAIT1: begin
            if (!lbusy && !rbusy) state_in = (op_ff == OP_ABS) ? S_PH2 : S_DONE;
         end
         S_WAIT2: begin
            if (!lbusy && !rbusy) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rvalid_ff || !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         loff_ff   <= '0;
         roff_ff   <= '0;
         macc_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         loff_ff  <= loff_in;
         roff_ff  <= roff_in;
         macc_ff  <= macc_in;
         if (state_ff == S_DONE && (!rvalid_ff || !rsp_stall)) rvalid_ff <= 1'b1;
         else if (!rsp_stall) rvalid_ff <= 1'b0;
      end
      status_ff <= status_in;
      if (state_ff == S_IDLE && req_valid) begin
         op_ff <= opcode_type'(req_opcode);
         a_ff  <= req_value_a;
         b_ff  <= req_value_b;
      end
      if (state_ff == S_DONE && (!rvalid_ff || !rsp_stall)) begin
         rstatus_ff <= status_ff;
         rmin_ff    <= macc_ff;
         rleft_ff   <= lne ? tl[50:0] : '0;
         rlb_ff     <= lne;
         rright_ff  <= rne ? tr[50:0] : '0;
         rrb_ff     <= rne;
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rvalid_ff;
   assign rsp_status        = rstatus_ff;
   assign rsp_minimum_value = rmin_ff;
   assign rsp_left_end      = rleft_ff;
   assign rsp_left_bounded  = rlb_ff;
   assign rsp_right_end     = rright_ff;
   assign rsp_right_bounded = rrb_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (!lbusy && !rbusy)) else $error("result while heap busy");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_DONE) else $error("stray result beat");
   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && status_in != ST_OK) |=> $stable(loff_ff) && $stable(roff_ff)
      && $stable(macc_ff)) else $error("rejected beat changed state");

endmodule

/* rtl/stcf_heap.sv */
module stcf_heap
   import stcf_pkg::*;
#(
   parameter int HEAP_CAPACITY = 1024,
   parameter bit IS_MIN = 1'b0,
   localparam int CW = $clog2(HEAP_CAPACITY + 1)
) (
   input  logic         clock,
   input  logic         reset,
   input  heap_cmd_type cmd,
   output logic         busy,
   output logic [CW-1:0] count,
   output entry_type    top
);

   localparam int IW = $clog2(HEAP_CAPACITY);
   localparam int KW = IW + 2;

   typedef enum logic [2:0] {
      H_IDLE, H_UP_RD, H_UP_CMP, H_UP_FIN, H_DN_CHK, H_DN_RD1, H_DN_RD2, H_DN_CMP
   } hstate_type;

   hstate_type    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] idx_ff, idx_in, bidx_ff, bidx_in, parent;
   entry_type     val_ff, val_in, best_ff, best_in, top_ff, top_in, rd_ff, wd;
   logic          we;
   logic [IW-1:0] wa, ra;
   logic [KW-1:0] c, c1, cntk;
   entry_type     mem [HEAP_CAPACITY];

   function automatic logic above(input entry_type x, input entry_type y);
      return IS_MIN ? (x < y) : (x > y);
   endfunction

   assign parent = (idx_ff - 1'b1) >> 1;
   assign c      = {1'b0, idx_ff, 1'b1};
   assign c1     = c + KW'(1);
   assign cntk   = KW'(cnt_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      bidx_in  = bidx_ff;
      val_in   = val_ff;
      best_in  = best_ff;
      top_in   = top_ff;
      we       = 1'b0;
      wa       = idx_ff;
      wd       = val_ff;
      ra       = '0;
      case (state_ff)
         H_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  HOP_PUSH: begin
                     cnt_in = cnt_ff + 1'b1;
                     val_in = cmd.value;
                     idx_in = IW'(cnt_ff);
                     if (cnt_ff == '0) begin
                        we     = 1'b1;
                        wa     = '0;
                        wd     = cmd.value;
                        top_in = cmd.value;
                     end else begin
                        state_in = H_UP_RD;
                     end
                  end
                  HOP_REPLACE: begin
                     val_in   = cmd.value;
                     idx_in   = '0;
                     state_in = H_DN_CHK;
                  end
                  HOP_CLEAR: cnt_in = '0;
                  default: ;
               endcase
            end
         end
         H_UP_RD: begin
            ra       = parent;
            state_in = H_UP_CMP;
         end
         H_UP_CMP: begin
            we = 1'b1;
            if (above(val_ff, rd_ff)) begin
               wd       = rd_ff;
               idx_in   = parent;
               state_in = (parent == '0) ? H_UP_FIN : H_UP_RD;
            end else begin
               state_in = H_IDLE;
            end
         end
         H_UP_FIN: begin
            we       = 1'b1;
            top_in   = val_ff;
            state_in = H_IDLE;
         end
         H_DN_CHK: begin
            if (c >= cntk) begin
               we = 1'b1;
               if (idx_ff == '0) top_in = val_ff;
               state_in = H_IDLE;
            end else begin
               ra       = c[IW-1:0];
               state_in = H_DN_RD1;
            end
         end
         H_DN_RD1: begin
            best_in = rd_ff;
            bidx_in = c[IW-1:0];
            if (c1 < cntk) begin
               ra       = c1[IW-1:0];
               state_in = H_DN_RD2;
            end else begin
               state_in = H_DN_CMP;
            end
         end
         H_DN_RD2: begin
            if (above(rd_ff, best_ff)) begin
               best_in = rd_ff;
               bidx_in = c1[IW-1:0];
            end
            state_in = H_DN_CMP;
         end
         H_DN_CMP: begin
            we = 1'b1;
            if (above(best_ff, val_ff)) begin
               wd = best_ff;
               if (idx_ff == '0) top_in = best_ff;
               idx_in   = bidx_ff;
               state_in = H_DN_CHK;
            end else begin
               if (idx_ff == '0) top_in = val_ff;
               state_in = H_IDLE;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff  <= idx_in;
      bidx_ff <= bidx_in;
      val_ff  <= val_in;
      best_ff <= best_in;
      top_ff  <= top_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   assign busy  = (state_ff != H_IDLE);
   assign count = cnt_ff;
   assign top   = top_ff;

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(HEAP_CAPACITY)) else $error("heap count above capacity");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == H_IDLE) else $error("heap command while busy");
   a_replace_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && cmd.op == HOP_REPLACE) |-> cnt_ff != '0)
      else $error("replace on empty heap");

endmodule

/* bench/slope_trick_convex_function_top_tb.sv */
`timescale 1ns / 100ps

module slope_trick_convex_function_top_tb;
   import stcf_pkg::*;

   localparam int CAPACITY = 1024;
   localparam longint LIM50 = longint'(1) << 49;
   localparam longint LIM48 = longint'(1) << 47;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      opcode_type op;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } beat_type;

   typedef struct {
      status_type status;
      logic signed [63:0] minimum;
      logic signed [50:0] left_end;
      logic left_bounded;
      logic signed [50:0] right_end;
      logic right_bounded;
   } result_type;

   class slope_function_model;
      longint heap[2][CAPACITY];
      int count[2];
      longint offset[2];
      longint minimum;
      result_type expected_rsp[$];
      int errors;

      function void clear_all();
         count = '{0, 0};
         offset = '{0, 0};
         minimum = 0;
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch on %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      function bit above(int side, longint x, longint y);
         return side ? (x < y) : (x > y);
      endfunction

      function bit fits50(longint v);
         return v >= -LIM50 && v < LIM50;
      endfunction

      function longint sat_add(longint x, longint y);
         longint s;
         s = x + y;
         if (y > 0 && s < x) return 64'sh7fff_ffff_ffff_ffff;
         if (y < 0 && s > x) return 64'sh8000_0000_0000_0000;
         return s;
      endfunction

      function longint top(int side);
         return heap[side][0] + offset[side];
      endfunction

      function void push(int side, longint v);
         int i, p;
         i = count[side];
         count[side] = i + 1;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (!above(side, v, heap[side][p])) break;
            heap[side][i] = heap[side][p];
            i = p;
         end
         heap[side][i] = v;
      endfunction

      function void replace_top(int side, longint v);
         int i, c;
         i = 0;
         forever begin
            c = 2 * i + 1;
            if (c >= count[side]) break;
            if (c + 1 < count[side] && above(side, heap[side][c + 1], heap[side][c])) c++;
            if (!above(side, heap[side][c], v)) break;
            heap[side][i] = heap[side][c];
            i = c;
         end
         heap[side][i] = v;
      endfunction

      function void add_a_minus_x(longint a);
         longint x;
         if (count[1] > 0 && top(1) < a) begin
            x = top(1);
            minimum = sat_add(minimum, a - x);
            replace_top(1, a - offset[1]);
            push(0, x - offset[0]);
         end else begin
            push(0, a - offset[0]);
         end
      endfunction

      function void add_x_minus_a(longint a);
         longint x;
         if (count[0] > 0 && a < top(0)) begin
            x = top(0);
            minimum = sat_add(minimum, x - a);
            replace_top(0, a - offset[0]);
            push(1, x - offset[1]);
         end else begin
            push(1, a - offset[1]);
         end
      endfunction

      function status_type apply(beat_type it);
         longint a, b, pushed, new_top, nl, nr;
         bit moves;
         a = it.a;
         b = it.b;
         case (it.op)
            OP_A_MINUS_X: begin
               if (count[0] >= CAPACITY) return ST_FULL;
               if (count[1] > 0 && top(1) < a && !fits50(top(1) - offset[0])) return ST_RANGE;
               add_a_minus_x(a);
            end
            OP_X_MINUS_A: begin
               if (count[1] >= CAPACITY) return ST_FULL;
               if (count[0] > 0 && a < top(0) && !fits50(top(0) - offset[1])) return ST_RANGE;
               add_x_minus_a(a);
            end
            OP_ABS: begin
               if (count[0] >= CAPACITY || count[1] >= CAPACITY) return ST_FULL;
               moves = count[1] > 0 && top(1) < a;
               pushed = moves ? top(1) : a;
               if (moves && !fits50(pushed - offset[0])) return ST_RANGE;
               new_top = (count[0] > 0 && top(0) > pushed) ? top(0) : pushed;
               if (a < new_top && !fits50(new_top - offset[1])) return ST_RANGE;
               add_a_minus_x(a);
               add_x_minus_a(a);
            end
            OP_SHIFT: begin
               if (a > b) return ST_REVERSED;
               nl = offset[0] + a;
               nr = offset[1] + b;
               if (nl < -LIM48 || nl >= LIM48 || nr < -LIM48 || nr >= LIM48) return ST_RANGE;
               offset[0] = nl;
               offset[1] = nr;
            end
            OP_CLR_LEFT: count[0] = 0;
            OP_CLR_RIGHT: count[1] = 0;
            OP_ADD_CONST: minimum = sat_add(minimum, a);
            default: ;
         endcase
         return ST_OK;
      endfunction

      function void note_request(beat_type it);
         result_type r;
         r.status = apply(it);
         r.minimum = minimum;
         r.left_bounded = count[0] > 0;
         r.left_end = r.left_bounded ? 51'(top(0)) : '0;
         r.right_bounded = count[1] > 0;
         r.right_end = r.right_bounded ? 51'(top(1)) : '0;
         expected_rsp.push_back(r);
      endfunction

      task check_response(result_type got);
         result_type w;
         if (expected_rsp.size() == 0) begin
            report("unexpected beat", 0, 0);
            return;
         end
         w = expected_rsp.pop_front();
         if (got.status !== w.status) report("status", got.status, w.status);
         if (got.minimum !== w.minimum) report("minimum_value", got.minimum, w.minimum);
         if (got.left_end !== w.left_end) report("left_end", got.left_end, w.left_end);
         if (got.left_bounded !== w.left_bounded)
            report("left_bounded", got.left_bounded, w.left_bounded);
         if (got.right_end !== w.right_end) report("right_end", got.right_end, w.right_end);
         if (got.right_bounded !== w.right_bounded)
            report("right_bounded", got.right_bounded, w.right_bounded);
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_opcode;
   logic signed [31:0] req_value_a;
   logic signed [31:0] req_value_b;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_status;
   logic signed [63:0] rsp_minimum_value;
   logic signed [50:0] rsp_left_end;
   logic rsp_left_bounded;
   logic signed [50:0] rsp_right_end;
   logic rsp_right_bounded;

   slope_trick_convex_function_top dut (.*);

   slope_function_model model = new();
   beat_type stim_q[$];
   beat_type cur;
   int send_idle_pct;
   int stall_pct;
   longint cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) model.note_request(cur);
         if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur = stim_q.pop_front();
            req_opcode <= cur.op;
            req_value_a <= cur.a;
            req_value_b <= cur.b;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = status_type'(rsp_status);
         got.minimum = rsp_minimum_value;
         got.left_end = rsp_left_end;
         got.left_bounded = rsp_left_bounded;
         got.right_end = rsp_right_end;
         got.right_bounded = rsp_right_bounded;
         model.check_response(got);
      end
      rsp_stall <= $urandom_range(99) < stall_pct;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task queue_beat(opcode_type op, int a, int b);
      beat_type it;
      it.op = op;
      it.a = a;
      it.b = b;
      stim_q.push_back(it);
   endtask

   task drain();
      while (stim_q.size() > 0 || req_valid || model.expected_rsp.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function int pick_value();
      if ($urandom_range(9) == 0) return $urandom;
      return int'($urandom_range(400)) - 200;
   endfunction

   task random_beats(int n);
      int k, lo, hi;
      opcode_type op;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 22) op = OP_A_MINUS_X;
         else if (k < 44) op = OP_X_MINUS_A;
         else if (k < 64) op = OP_ABS;
         else if (k < 76) op = OP_SHIFT;
         else if (k < 79) op = OP_CLR_LEFT;
         else if (k < 82) op = OP_CLR_RIGHT;
         else if (k < 90) op = OP_ADD_CONST;
         else op = OP_QUERY;
         lo = pick_value();
         hi = pick_value();
         if (op == OP_SHIFT && $urandom_range(9) != 0 && lo > hi) begin
            k = lo;
            lo = hi;
            hi = k;
         end
         if (op >= OP_CLR_LEFT && op != OP_ADD_CONST) hi = $urandom;
         queue_beat(op, lo, hi);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = '0;
      req_value_a = '0;
      req_value_b = '0;
      rsp_stall = 1'b0;
      cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      model.clear_all();
      model.errors = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      queue_beat(OP_QUERY, 0, 0);
      queue_beat(OP_A_MINUS_X, 32'h7fff_ffff, 0);
      queue_beat(OP_X_MINUS_A, 32'h8000_0000, 0);
      queue_beat(OP_ABS, 0, 0);
      queue_beat(OP_A_MINUS_X, 32'h7fff_ffff, 32'hffff_ffff);
      queue_beat(OP_X_MINUS_A, 32'h8000_0000, 0);
      queue_beat(OP_SHIFT, 5, -5);
      queue_beat(OP_SHIFT, 32'h8000_0000, 32'h7fff_ffff);
      queue_beat(OP_ABS, 32'h8000_0000, 0);
      queue_beat(OP_ABS, 32'h7fff_ffff, 0);
      queue_beat(OP_ADD_CONST, 32'h7fff_ffff, 0);
      queue_beat(OP_ADD_CONST, 32'h8000_0000, 0);
      queue_beat(OP_CLR_LEFT, 0, 0);
      queue_beat(OP_QUERY, -1, -1);
      queue_beat(OP_CLR_RIGHT, 0, 0);
      queue_beat(OP_QUERY, 0, 0);
      queue_beat(OP_ABS, 17, 0);
      queue_beat(OP_SHIFT, -3, 9);
      queue_beat(OP_QUERY, 0, 0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         random_beats(110);
         drain();
      end

      if (model.errors == 0 && model.expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
